### hdl/rate_limited_pursuit_step_defines.svh
// Assertion macros for the pursuit step block.
`ifndef RATE_LIMITED_PURSUIT_STEP_DEFINES_SVH
`define RATE_LIMITED_PURSUIT_STEP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RLPS_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rlps assertion failed");

// Next-cycle implication, disabled in reset.
`define RLPS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rlps assertion failed");

`endif

### hdl/rlps_pkg.sv
`default_nettype none
package rlps_pkg;
  localparam int PW     = 14;  // pointer width
  localparam int SW     = 15;  // sprite position width
  localparam int FW     = 6;   // frame counter width
  localparam int SPW    = 10;  // speed width
  localparam int DW     = 17;  // signed offset width
  localparam int MW     = 15;  // offset magnitude / multiplier operand width
  localparam int PRODW  = 30;
  localparam int SUMW   = 32;
  localparam int RADW   = 28;
  localparam int ROOTW  = 14;
  localparam int DISTW  = 16;
  localparam int DIVW   = 25;
  localparam int CW     = 5;
  localparam int ROOT_STEPS = 14;
  localparam int DIV_STEPS  = 25;

  localparam logic [1:0] MUL_XX = 2'd0;
  localparam logic [1:0] MUL_YY = 2'd1;
  localparam logic [1:0] MUL_XS = 2'd2;
  localparam logic [1:0] MUL_YS = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sq_save;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       qx_save;
    logic       update;
  } rlps_cmd_t;

  typedef struct packed {
    logic out_free;
  } rlps_status_t;
endpackage
`default_nettype wire

### hdl/rlps_ctrl.sv
`default_nettype none
module rlps_ctrl import rlps_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire rlps_status_t status,
  output rlps_cmd_t         cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;

  logic [3:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          axis, axis_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    axis_next  = axis;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SQX;
        end
      end
      S_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_XX;
        state_next  = S_SQY;
      end
      S_SQY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_YY;
        cmd.sq_save = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.root_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + CW'(1);
        if (cnt == CW'(ROOT_STEPS - 1)) begin
          axis_next  = 1'b0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = axis ? MUL_YS : MUL_XS;
        cmd.qx_save = axis;  // x quotient still sits in the divider
        state_next  = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CW'(1);
        if (cnt == CW'(DIV_STEPS - 1)) begin
          if (axis) begin
            state_next = S_UPD;
          end else begin
            axis_next  = 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_UPD: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      axis  <= axis_next;
    end
  end
endmodule
`default_nettype wire

### hdl/rlps_dp.sv
`default_nettype none
module rlps_dp import rlps_pkg::*; #(
  parameter int HALF_SIZE = 32,
  parameter int FRAMES    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rlps_cmd_t            cmd,
  output rlps_status_t              status,
  input  wire logic                 cfg_we,
  input  wire logic [SPW-1:0]       cfg_wdata,
  input  wire logic [PW-1:0]        pointer_x,
  input  wire logic [PW-1:0]        pointer_y,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [SW-1:0]      sprite_x,
  output logic signed [SW-1:0]      sprite_y,
  output logic [FW-1:0]             frame_index
);
  logic [SPW-1:0]   speed;
  logic [SW-1:0]    pos_x, pos_y;
  logic [FW-1:0]    frame;
  logic [MW-1:0]    ax, ay;
  logic             sx, sy;
  logic [PRODW-1:0] prod, sqx;
  logic [RADW-1:0]  rad;
  logic [1:0]       k;
  logic [ROOTW-1:0] root;
  logic [MW-1:0]    rrem;
  logic [DIVW-1:0]  dq;
  logic [DISTW-1:0] drem;
  logic [MW-1:0]    qx;

  // offsets from sprite centre
  logic [DW-1:0] dxf, dyf, dxn, dyn;
  assign dxf = {3'b000, pointer_x} - {{2{pos_x[SW-1]}}, pos_x} - DW'(HALF_SIZE);
  assign dyf = {3'b000, pointer_y} - {{2{pos_y[SW-1]}}, pos_y} - DW'(HALF_SIZE);
  assign dxn = -dxf;
  assign dyn = -dyf;

  // shared multiplier
  logic [MW-1:0] ma, mb;
  always_comb begin
    case (cmd.mul_sel)
      MUL_XX:  begin ma = ax; mb = ax; end
      MUL_YY:  begin ma = ay; mb = ay; end
      MUL_XS:  begin ma = ax; mb = MW'(speed); end
      default: begin ma = ay; mb = MW'(speed); end
    endcase
  end

  // sum and range reduction by quarters
  logic [SUMW-1:0] sum;
  logic [RADW-1:0] rad_init;
  logic [1:0]      k_init;
  assign sum = {2'b00, sqx} + {2'b00, prod};
  always_comb begin
    if (sum[31:30] != 2'b00) begin
      k_init = 2'd2; rad_init = sum[31:4];
    end else if (sum[29:28] != 2'b00) begin
      k_init = 2'd1; rad_init = sum[29:2];
    end else begin
      k_init = 2'd0; rad_init = sum[27:0];
    end
  end

  // restoring root step
  logic [MW+1:0] rtry, rtrial;
  assign rtry   = {rrem, rad[RADW-1:RADW-2]};
  assign rtrial = {1'b0, root, 2'b01};

  logic [DISTW-1:0] distance;
  always_comb begin
    case (k)
      2'd0:    distance = {2'b00, root};
      2'd1:    distance = {1'b0, root, 1'b0};
      default: distance = {root, 2'b00};
    endcase
  end

  // restoring divide step
  logic [DISTW:0] dtry;
  assign dtry = {drem, dq[DIVW-1]};

  // position update
  logic          clamp;
  logic [MW-1:0] mag_x, mag_y, del_x, del_y;
  assign clamp = distance > DISTW'(speed);
  assign mag_x = clamp ? qx : ax;
  assign mag_y = clamp ? dq[MW-1:0] : ay;
  assign del_x = sx ? -mag_x : mag_x;
  assign del_y = sy ? -mag_y : mag_y;

  // frame always stays below FRAMES, so one compare wraps it
  logic [FW:0]   frame_inc;
  logic [FW-1:0] frame_next;
  assign frame_inc  = {1'b0, frame} + (FW+1)'(1);
  assign frame_next = (frame_inc >= (FW+1)'(FRAMES)) ? '0 : frame_inc[FW-1:0];

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sx <= dxf[DW-1];
      sy <= dyf[DW-1];
      ax <= dxf[DW-1] ? dxn[MW-1:0] : dxf[MW-1:0];
      ay <= dyf[DW-1] ? dyn[MW-1:0] : dyf[MW-1:0];
    end
    if (cmd.mul_en) prod <= PRODW'(ma) * PRODW'(mb);
    if (cmd.sq_save) sqx <= prod;
    if (cmd.root_init) begin
      rad  <= rad_init;
      k    <= k_init;
      root <= '0;
      rrem <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[RADW-3:0], 2'b00};
      if (rtry >= rtrial) begin
        rrem <= MW'(rtry - rtrial);
        root <= {root[ROOTW-2:0], 1'b1};
      end else begin
        rrem <= rtry[MW-1:0];
        root <= {root[ROOTW-2:0], 1'b0};
      end
    end
    if (cmd.qx_save) qx <= dq[MW-1:0];
    if (cmd.div_init) begin
      dq   <= prod[DIVW-1:0];
      drem <= '0;
    end else if (cmd.div_step) begin
      if (dtry >= {1'b0, distance}) begin
        drem <= DISTW'(dtry - {1'b0, distance});
        dq   <= {dq[DIVW-2:0], 1'b1};
      end else begin
        drem <= dtry[DISTW-1:0];
        dq   <= {dq[DIVW-2:0], 1'b0};
      end
    end
    if (cmd.update) begin
      sprite_x    <= pos_x + del_x;
      sprite_y    <= pos_y + del_y;
      frame_index <= frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed     <= SPW'(40);
      pos_x     <= '0;
      pos_y     <= '0;
      frame     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) speed <= cfg_wdata;
      if (cmd.update) begin
        pos_x     <= pos_x + del_x;
        pos_y     <= pos_y + del_y;
        frame     <= frame_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/rate_limited_pursuit_step.sv
// Rate-limited pursuit step.
// Input channel (in_valid/in_ready) carries one pointer position per
// transaction; output channel (out_valid/out_ready) returns the new sprite
// corner and animation frame, one result transaction per input.
// speed is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// From input acceptance to out_valid the block does the squares and sum,
// the bit-serial root, two passes through the shared 25-step restoring
// divider, and the update; in_ready returns the cycle after the update.
// One transaction in flight at a time; in_ready is high only when idle.
// The result sits in an output register: a new input is taken while it
// waits, but the next update holds until out_ready frees that register.
// Reset (rst, synchronous): position and frame go to zero, speed to 40,
// no result pending.
`default_nettype none
module rate_limited_pursuit_step import rlps_pkg::*; #(
  parameter int HALF_SIZE = 32,
  parameter int FRAMES    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [SPW-1:0]    cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PW-1:0]     pointer_x,
  input  wire logic [PW-1:0]     pointer_y,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [SW-1:0]   sprite_x,
  output logic signed [SW-1:0]   sprite_y,
  output logic [FW-1:0]          frame_index
);
  rlps_cmd_t    cmd;     // controller -> datapath
  rlps_status_t status;  // datapath -> controller

  // sequencer: squares, root iterations, two divides, update
  rlps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // shared multiplier, root and divide units, state and output register
  rlps_dp #(
    .HALF_SIZE (HALF_SIZE),
    .FRAMES    (FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pointer_x   (pointer_x),
    .pointer_y   (pointer_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sprite_x    (sprite_x),
    .sprite_y    (sprite_y),
    .frame_index (frame_index)
  );
endmodule
`default_nettype wire

### hdl/rlps_chk.sv
`default_nettype none
`include "rate_limited_pursuit_step_defines.svh"
module rlps_chk import rlps_pkg::*; #(
  parameter int FRAMES = 8
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic signed [SW-1:0] sprite_x,
  input wire logic signed [SW-1:0] sprite_y,
  input wire logic [FW-1:0]       frame_index
);
  // one transaction in flight
  `RLPS_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready)
  // a fresh result never appears the cycle after the block was idle
  `RLPS_ASSERT_IMPL(a_rise_busy, $rose(out_valid), !$past(in_ready))
  // frame stays below FRAMES
  `RLPS_ASSERT_IMPL(a_frame_range, out_valid, {1'b0, frame_index} < (FW+1)'(FRAMES))
  // stalled result holds
  `RLPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(sprite_x) && $stable(sprite_y))
endmodule

bind rate_limited_pursuit_step rlps_chk #(.FRAMES(FRAMES)) u_rlps_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .sprite_x    (sprite_x),
  .sprite_y    (sprite_y),
  .frame_index (frame_index)
);
`default_nettype wire
